### rtl/spc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// spc_pkg: shared types and codes for the shape pair collision test
// pair item and result layouts, pair kind codes, default coordinate width
// ============================================================================
package spc_pkg;

    localparam int FIELD_W        = 16;
    localparam int KIND_W         = 2;
    localparam int COORD_BITS_DEF = 16;

    // pair kind codes
    localparam logic [KIND_W-1:0] KIND_RECT_RECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECT_CIRC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CIRC_CIRC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] a_x;
        logic [FIELD_W-1:0] a_y;
        logic [FIELD_W-1:0] a_w;
        logic [FIELD_W-1:0] a_h;
        logic [FIELD_W-1:0] a_r;
        logic [FIELD_W-1:0] b_x;
        logic [FIELD_W-1:0] b_y;
        logic [FIELD_W-1:0] b_w;
        logic [FIELD_W-1:0] b_h;
        logic [FIELD_W-1:0] b_r;
    } t_pair_item;

    typedef struct packed {
        logic hit;
    } t_hit_result;

endpackage
`default_nettype wire

### rtl/spc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// spc_if: valid/ready channels of the shape pair collision test
// one channel for pair items, one for hit results
// ============================================================================
interface spc_pair_if;
    logic                valid;
    logic                ready;
    spc_pkg::t_pair_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spc_hit_if;
    logic                 valid;
    logic                 ready;
    spc_pkg::t_hit_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/spc_pair_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// spc_pair_eval: overlap test for one registered shape pair
// four squarers serve the rect-circle test, three of them shared with the circle-circle test
// ============================================================================
module spc_pair_eval #(
    parameter int CW = spc_pkg::COORD_BITS_DEF
) (
    input  spc_pkg::t_pair_item i_item,
    output logic                o_hit
);

    localparam int MW = CW + 1;     // magnitude width
    localparam int SW = CW + 2;     // signed difference width
    localparam int QW = 2 * MW;     // square width
    localparam int AW = QW + 1;     // sum of squares width

    logic [CW-1:0] ax, ay, aw, ah, ar, bx, by, bw, bh, br;
    logic [MW-1:0] a_right, a_bot, b_right, b_bot;
    logic [MW-1:0] br_e, dx_m, dy_m, rsum, dl, dr, dh, dt_m, db_m;
    logic signed [SW-1:0] dt, db, dt_neg, db_neg;
    logic [MW-1:0] s0, s1, s2, s3;
    logic [QW-1:0] q0, q1, q2, q3;
    logic [AW-1:0] sum_t, sum_b, r2;
    logic          cc, yin, in_rect, left, right;
    logic          rr_hit, cc_hit, hl, hr, hm, rc_hit;

    assign ax = i_item.a_x[CW-1:0];
    assign ay = i_item.a_y[CW-1:0];
    assign aw = i_item.a_w[CW-1:0];
    assign ah = i_item.a_h[CW-1:0];
    assign ar = i_item.a_r[CW-1:0];
    assign bx = i_item.b_x[CW-1:0];
    assign by = i_item.b_y[CW-1:0];
    assign bw = i_item.b_w[CW-1:0];
    assign bh = i_item.b_h[CW-1:0];
    assign br = i_item.b_r[CW-1:0];

    assign a_right = {1'b0, ax} + {1'b0, aw};
    assign a_bot   = {1'b0, ay} + {1'b0, ah};
    assign b_right = {1'b0, bx} + {1'b0, bw};
    assign b_bot   = {1'b0, by} + {1'b0, bh};
    assign br_e    = {1'b0, br};
    assign rsum    = {1'b0, ar} + {1'b0, br};

    assign dx_m = (ax >= bx) ? {1'b0, ax - bx} : {1'b0, bx - ax};
    assign dy_m = (ay >= by) ? {1'b0, ay - by} : {1'b0, by - ay};

    // rect a against circle b
    assign yin     = (by >= ay) && ({1'b0, by} <= a_bot);
    assign in_rect = (bx >= ax) && ({1'b0, bx} <= a_right) && yin;
    assign left    = (bx <= ax);
    assign right   = ({1'b0, bx} >= a_right);
    assign dl      = {1'b0, ax - bx};
    assign dr      = {1'b0, bx} - a_right;
    assign dh      = left ? dl : dr;

    assign dt     = $signed({2'b00, by}) - $signed({2'b00, ay});
    assign db     = dt - $signed({2'b00, ah});
    assign dt_neg = -dt;
    assign db_neg = -db;
    assign dt_m   = dt[SW-1] ? dt_neg[MW-1:0] : dt[MW-1:0];
    assign db_m   = db[SW-1] ? db_neg[MW-1:0] : db[MW-1:0];

    // squarer operand selection
    assign cc = (i_item.kind == spc_pkg::KIND_CIRC_CIRC);
    assign s0 = cc ? dx_m : dh;
    assign s1 = cc ? dy_m : dt_m;
    assign s2 = db_m;
    assign s3 = cc ? rsum : br_e;

    assign q0 = s0 * s0;
    assign q1 = s1 * s1;
    assign q2 = s2 * s2;
    assign q3 = s3 * s3;

    assign sum_t = {1'b0, q0} + {1'b0, q1};
    assign sum_b = {1'b0, q0} + {1'b0, q2};
    assign r2    = {1'b0, q3};

    assign rr_hit = ({1'b0, ax} < b_right) && ({1'b0, ay} < b_bot)
                 && (a_right > {1'b0, bx}) && (a_bot > {1'b0, by});
    assign cc_hit = (sum_t < r2);

    // left corners inclusive, right corners strict
    assign hl = ((dh <= br_e) && yin) || (sum_t <= r2) || (sum_b <= r2);
    assign hr = ((dh <= br_e) && yin) || (sum_t < r2) || (sum_b < r2);
    assign hm = (dt_m <= br_e) || (db_m <= br_e);
    assign rc_hit = in_rect || (left ? hl : (right ? hr : hm));

    always_comb begin
        case (i_item.kind)
            spc_pkg::KIND_RECT_RECT: o_hit = rr_hit;
            spc_pkg::KIND_RECT_CIRC: o_hit = rc_hit;
            spc_pkg::KIND_CIRC_CIRC: o_hit = cc_hit;
            default:                 o_hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/shape_pair_collision_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// a pair passes the input register, then the result register, before its hit result can transfer
// throughput: one pair per cycle while the result side does not stall; the squarers and
// compares sit in one stage between the input register and the result register
// a stalled result holds while the input register can still take one pair
// reset (synchronous, active low) clears both valid flags; no sweep needed
// ============================================================================
// shape_pair_collision_test_unit: pipelined 2-D shape overlap test
// rect-rect, rect-circle and circle-circle pairs, one hit bit per pair
// ============================================================================
module shape_pair_collision_test_unit #(
    parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    spc_pair_if.sink        i_pair,
    spc_hit_if.source       o_hit
);

    // coordinates are the low COORD_BITS bits of each 16-bit field, at most all 16
    localparam int CW = (COORD_BITS < spc_pkg::FIELD_W) ? COORD_BITS : spc_pkg::FIELD_W;

    // input register stage
    logic                r_in_vld, n_in_vld;
    spc_pkg::t_pair_item r_in;

    // result register stage
    logic                r_out_vld, n_out_vld;
    logic                r_out_hit;

    logic                s1_rdy, s2_rdy;
    logic                in_xfer, s2_load;
    logic                eval_hit;

    // a stage can load when it is empty or its content moves on this cycle
    assign s2_rdy  = !r_out_vld || o_hit.ready;
    assign s1_rdy  = !r_in_vld || s2_rdy;
    assign in_xfer = i_pair.valid && s1_rdy;
    assign s2_load = r_in_vld && s2_rdy;

    assign i_pair.ready = s1_rdy;

    assign n_in_vld  = s1_rdy ? i_pair.valid : r_in_vld;
    assign n_out_vld = s2_rdy ? r_in_vld : r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_pair.data;
        end
        if (s2_load) begin
            r_out_hit <= eval_hit;
        end
    end

    spc_pair_eval #(
        .CW (CW)
    ) u_eval (
        .i_item (r_in),
        .o_hit  (eval_hit)
    );

    assign o_hit.valid    = r_out_vld;
    assign o_hit.data.hit = r_out_hit;

`ifndef SYNTHESIS
    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_pair.ready)
        else $error("input stalled with empty result register");

    // an accepted pair lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pair.valid && i_pair.ready) |=> r_in_vld)
        else $error("accepted pair lost");

    // a pair that moves on becomes a pending result
    a_out_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && s2_rdy) |=> o_hit.valid)
        else $error("result lost between stages");

    // a pair of no kind never reports a hit
    a_none_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && s2_rdy && r_in.kind == spc_pkg::KIND_NONE) |=> !o_hit.data.hit)
        else $error("hit reported for unused pair kind");
`endif

endmodule
`default_nettype wire

### bench/spc_hit_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// spc_hit_checker: hit prediction and comparison for the shape pair test
// watches the pair and hit channels, predicts one hit bit per pair transfer
// and compares each hit transfer with the oldest pending prediction
// ============================================================================
module spc_hit_checker #(
    parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_pair_valid,
    input  wire                  i_pair_ready,
    input  spc_pkg::t_pair_item  i_pair_data,
    input  wire                  i_hit_valid,
    input  wire                  i_hit_ready,
    input  spc_pkg::t_hit_result i_hit_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    localparam longint COORD_MASK = (longint'(1) << COORD_BITS) - 1;

    bit expected_hits[$];
    int mismatch_count = 0;

    function automatic bit predict_hit(input spc_pkg::t_pair_item p);
        longint ax, ay, aw, ah, ar, bx, by, bw, bh, br;
        longint dt, db, d, r2;
        bit     yin;
        ax = longint'(p.a_x) & COORD_MASK;
        ay = longint'(p.a_y) & COORD_MASK;
        aw = longint'(p.a_w) & COORD_MASK;
        ah = longint'(p.a_h) & COORD_MASK;
        ar = longint'(p.a_r) & COORD_MASK;
        bx = longint'(p.b_x) & COORD_MASK;
        by = longint'(p.b_y) & COORD_MASK;
        bw = longint'(p.b_w) & COORD_MASK;
        bh = longint'(p.b_h) & COORD_MASK;
        br = longint'(p.b_r) & COORD_MASK;
        case (p.kind)
            spc_pkg::KIND_RECT_RECT: begin
                return (ax < bx + bw) && (ay < by + bh) && (ax + aw > bx) && (ay + ah > by);
            end
            spc_pkg::KIND_CIRC_CIRC: begin
                return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) < (ar + br) * (ar + br);
            end
            spc_pkg::KIND_RECT_CIRC: begin
                // rectangle is shape a, circle is shape b
                yin = (by >= ay) && (by <= ay + ah);
                dt  = by - ay;
                db  = by - ay - ah;
                r2  = br * br;
                if (bx >= ax && bx <= ax + aw && yin) begin
                    return 1'b1;
                end
                // left side: corners inclusive
                if (bx <= ax) begin
                    d = ax - bx;
                    return (d <= br && yin) || (d * d + dt * dt <= r2)
                        || (d * d + db * db <= r2);
                end
                // right side: corners strict
                if (bx >= ax + aw) begin
                    d = bx - ax - aw;
                    return (d <= br && yin) || (d * d + dt * dt < r2)
                        || (d * d + db * db < r2);
                end
                return (dt <= br && -dt <= br) || (db <= br && -db <= br);
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        bit exp_hit;
        if (i_rst_n) begin
            if (i_pair_valid && i_pair_ready) begin
                expected_hits.push_back(predict_hit(i_pair_data));
            end
            if (i_hit_valid && i_hit_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("hit transfer with no pair pending: actual %0d", i_hit_data.hit);
                    mismatch_count++;
                end else begin
                    exp_hit = expected_hits.pop_front();
                    if (i_hit_data.hit !== exp_hit) begin
                        $error("hit mismatch: expected %0d actual %0d", exp_hit, i_hit_data.hit);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_hits.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: stimulus and verdict for shape_pair_collision_test_unit
// directed corner pairs of every kind, then random local scenes and full-range
// pairs under random idling on both channels; checking lives in the checker
// ============================================================================
module tb_top;

    localparam int FW           = spc_pkg::FIELD_W;
    localparam int RANDOM_PAIRS = 1625;
    localparam int CALM_TAIL    = 150;     // last pairs run with no idling
    localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
    localparam int DRAIN_LIMIT  = 2000;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    int   stall_left  = 0;

    spc_pair_if pair_ch ();
    spc_hit_if  hit_ch ();

    shape_pair_collision_test_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pair  (pair_ch),
        .o_hit   (hit_ch)
    );

    spc_hit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pair_valid (pair_ch.valid),
        .i_pair_ready (pair_ch.ready),
        .i_pair_data  (pair_ch.data),
        .i_hit_valid  (hit_ch.valid),
        .i_hit_ready  (hit_ch.ready),
        .i_hit_data   (hit_ch.data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // run guard: a hung handshake ends here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("shape_pair_collision_test_unit verification failed");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts while idling is on
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            hit_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 8);
            hit_ch.ready <= 1'b0;
        end else begin
            hit_ch.ready <= 1'b1;
        end
    end

    function automatic spc_pkg::t_pair_item make_pair(
        input logic [spc_pkg::KIND_W-1:0] kind,
        input logic [FW-1:0]              ax, ay, aw, ah, ar,
        input logic [FW-1:0]              bx, by, bw, bh, br
    );
        spc_pkg::t_pair_item p;
        p.kind = kind;
        p.a_x  = ax;
        p.a_y  = ay;
        p.a_w  = aw;
        p.a_h  = ah;
        p.a_r  = ar;
        p.b_x  = bx;
        p.b_y  = by;
        p.b_w  = bw;
        p.b_h  = bh;
        p.b_r  = br;
        return p;
    endfunction

    // mostly local scenes where the shapes sit near each other, so hits,
    // misses and every rect-circle region show up; the rest is full range
    function automatic spc_pkg::t_pair_item make_random_pair();
        spc_pkg::t_pair_item p;
        int unsigned         pick;
        int                  span;
        int                  base_x;
        int                  base_y;
        p.a_x = FW'($urandom);
        p.a_y = FW'($urandom);
        p.a_w = FW'($urandom);
        p.a_h = FW'($urandom);
        p.a_r = FW'($urandom);
        p.b_x = FW'($urandom);
        p.b_y = FW'($urandom);
        p.b_w = FW'($urandom);
        p.b_h = FW'($urandom);
        p.b_r = FW'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            p.kind = spc_pkg::KIND_RECT_RECT;
        end else if (pick < 13) begin
            p.kind = spc_pkg::KIND_RECT_CIRC;
        end else if (pick < 19) begin
            p.kind = spc_pkg::KIND_CIRC_CIRC;
        end else begin
            p.kind = spc_pkg::KIND_NONE;
        end
        if ($urandom_range(0, 3) != 0) begin
            span   = 1 << $urandom_range(1, 12);
            base_x = int'($urandom_range(0, 65535));
            base_y = int'($urandom_range(0, 65535));
            p.a_x  = FW'(base_x);
            p.a_y  = FW'(base_y);
            p.a_w  = FW'($urandom_range(0, span));
            p.a_h  = FW'($urandom_range(0, span));
            p.a_r  = FW'($urandom_range(0, span));
            // second shape lands left of, over, or right of the first
            p.b_x  = FW'(base_x + int'($urandom_range(0, 3 * span)) - span);
            p.b_y  = FW'(base_y + int'($urandom_range(0, 3 * span)) - span);
            p.b_w  = FW'($urandom_range(0, span));
            p.b_h  = FW'($urandom_range(0, span));
            p.b_r  = FW'($urandom_range(0, span));
        end
        return p;
    endfunction

    // one pair transfer, with an optional idle burst ahead of it
    task automatic send_pair(input spc_pkg::t_pair_item p);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        do @(posedge clk); while (!pair_ch.ready);
    endtask

    task automatic wait_results_drained();
        int waited;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    initial begin
        rst_n         <= 1'b0;
        idle_on       <= 1'b0;
        pair_ch.valid <= 1'b0;
        pair_ch.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners, no idling
        // rect-rect: edges touching is a miss (strict), plain overlap, all max, zero size
        send_pair(make_pair(spc_pkg::KIND_RECT_RECT, 0, 0, 10, 10, 16'hffff,
                            10, 0, 5, 5, 0));
        send_pair(make_pair(spc_pkg::KIND_RECT_RECT, 0, 0, 10, 10, 0,
                            9, 9, 5, 5, 16'hffff));
        send_pair(make_pair(spc_pkg::KIND_RECT_RECT,
                            16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                            16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_pair(make_pair(spc_pkg::KIND_RECT_RECT, 5, 5, 0, 0, 0, 5, 5, 0, 0, 0));
        // circle-circle: exact touch is a miss, slight overlap, extremes, zero radii
        send_pair(make_pair(spc_pkg::KIND_CIRC_CIRC, 100, 100, 0, 0, 2, 103, 104, 0, 0, 3));
        send_pair(make_pair(spc_pkg::KIND_CIRC_CIRC, 100, 100, 16'hffff, 16'hffff, 3,
                            103, 104, 16'hffff, 16'hffff, 3));
        send_pair(make_pair(spc_pkg::KIND_CIRC_CIRC, 0, 0, 0, 0, 16'hffff,
                            16'hffff, 16'hffff, 0, 0, 16'hffff));
        send_pair(make_pair(spc_pkg::KIND_CIRC_CIRC, 0, 0, 0, 0, 0,
                            16'hffff, 16'hffff, 0, 0, 0));
        send_pair(make_pair(spc_pkg::KIND_CIRC_CIRC, 7, 7, 0, 0, 0, 7, 7, 0, 0, 0));
        // rect-circle: centre on the corner of the rectangle counts as inside, then all zero and extremes
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 16'hffff,
                            30, 30, 16'hffff, 7, 0));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 0, 0, 16'hffff, 16'hffff, 0,
                            16'hffff, 16'hffff, 0, 0, 16'hffff));
        // centre left: side distance equal to the radius, then the corners (inclusive)
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 5, 15, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 7, 6, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 7, 34, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 6, 6, 0, 0, 5));
        // centre right: side distance equal to the radius, corners strict
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 35, 20, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 33, 6, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 33, 7, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 33, 34, 0, 0, 5));
        // centre beside horizontally: above and below the rectangle
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 20, 5, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 20, 4, 0, 0, 5));
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 10, 10, 20, 20, 0, 20, 35, 0, 0, 5));
        // far corner with a tiny radius
        send_pair(make_pair(spc_pkg::KIND_RECT_CIRC, 16'hffff, 0, 0, 0, 0,
                            0, 16'hffff, 0, 0, 1));
        // unused kind: overlapping shapes still give no hit
        send_pair(make_pair(spc_pkg::KIND_NONE,
                            16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                            16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));

        // hold the pair channel until the pipeline has emptied
        pair_ch.valid <= 1'b0;
        wait_results_drained();

        // random part: idling switched per block of pairs, off for the tail
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            if (i % 200 == 0) begin
                idle_on <= (i < RANDOM_PAIRS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_PAIRS - CALM_TAIL) begin
                idle_on <= 1'b0;
            end
            send_pair(make_random_pair());
        end
        pair_ch.valid <= 1'b0;

        // drain, then wait for anything unexpected to surface
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (pending == 0 && mismatches == 0) begin
            $display("shape_pair_collision_test_unit verification clean");
        end else begin
            $display("shape_pair_collision_test_unit verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/spc_pkg.sv
rtl/spc_if.sv
rtl/spc_pair_eval.sv
rtl/shape_pair_collision_test_unit.sv
bench/spc_hit_checker.sv
bench/tb_top.sv
